// ===== rtl/ibst_pkg.sv =====
// ----------------------------------------------------------------------------
// ibst_pkg
// Shared types and constants for the implicit-array binary search tree engine.
// ----------------------------------------------------------------------------
package ibst_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CHILD_W     = IDX_W + 2;              // holds 2*idx+2
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed result field widths
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int LEN_W    = 4;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd4;

  // Request item
  typedef struct packed {
    logic                        opcode;
    logic signed [KEY_WIDTH-1:0] key;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [LEN_W-1:0]    path_length;
  } out_item_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic                        valid;
    logic signed [KEY_WIDTH-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // RAM access request from the walker
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/ibst_ram.sv =====
// ----------------------------------------------------------------------------
// ibst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ibst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ibst_walk.sv =====
// ----------------------------------------------------------------------------
// ibst_walk
// Tree walker: clears the table after reset, then walks one level per cycle
// through the entry RAM for each insert or search item.
// ----------------------------------------------------------------------------
module ibst_walk (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ibst_pkg::in_item_t req,
  output ibst_pkg::mem_req_t mem,
  input  ibst_pkg::entry_t   rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output ibst_pkg::out_item_t res
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK, S_RES} state_t;

  state_t                               state;
  logic [ibst_pkg::IDX_W-1:0]           clr_addr;
  logic                                 opcode;
  logic signed [ibst_pkg::KEY_WIDTH-1:0] key;
  logic [ibst_pkg::IDX_W-1:0]           idx;
  logic [ibst_pkg::LEN_W-1:0]           len;
  logic [ibst_pkg::CNT_W-1:0]           count;

  logic                                 full;
  logic                                 lt;
  logic                                 hit;
  logic                                 beyond;
  logic [ibst_pkg::CHILD_W-1:0]         child;
  logic [ibst_pkg::LEN_W-1:0]           len_inc;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RES);

  // compare against the node just read and find the next slot
  assign full    = (count == ibst_pkg::CNT_W'(ibst_pkg::TABLE_DEPTH));
  assign lt      = ($signed(key) < $signed(rdata.key));
  assign hit     = (key == rdata.key);
  assign child   = {1'b0, idx, 1'b0} + (lt ? ibst_pkg::CHILD_W'(1) : ibst_pkg::CHILD_W'(2));
  assign beyond  = (child >= ibst_pkg::CHILD_W'(ibst_pkg::TABLE_DEPTH));
  assign len_inc = (len == '1) ? len : len + 1'b1;

  // RAM requests
  always_comb begin
    mem = '0;
    unique case (state)
      S_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_addr;
      end
      S_IDLE: begin
        mem.re    = req_valid;
      end
      S_WALK: begin
        if (!rdata.valid) begin
          if (opcode == ibst_pkg::OP_INSERT) begin
            mem.we          = 1'b1;
            mem.waddr       = idx;
            mem.wdata.valid = 1'b1;
            mem.wdata.key   = key;
          end
        end else if (!(opcode == ibst_pkg::OP_SEARCH && hit) && !beyond) begin
          mem.re    = 1'b1;
          mem.raddr = child[ibst_pkg::IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // control state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ibst_pkg::IDX_W'(ibst_pkg::TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            opcode <= req.opcode;
            key    <= req.key;
            idx    <= '0;
            len    <= '0;
            if (req.opcode == ibst_pkg::OP_INSERT && full) begin
              res.status      <= ibst_pkg::ST_FULL;
              res.slot_index  <= '0;
              res.path_length <= '0;
              state           <= S_RES;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (!rdata.valid) begin
            // empty slot ends the walk
            if (opcode == ibst_pkg::OP_INSERT) begin
              res.status     <= ibst_pkg::ST_INSERTED;
              res.slot_index <= ibst_pkg::SLOT_W'(idx);
              count          <= count + 1'b1;
            end else begin
              res.status     <= ibst_pkg::ST_NOT_FOUND;
              res.slot_index <= '0;
            end
            res.path_length <= len;
            state           <= S_RES;
          end else if (opcode == ibst_pkg::OP_SEARCH && hit) begin
            res.status      <= ibst_pkg::ST_FOUND;
            res.slot_index  <= ibst_pkg::SLOT_W'(idx);
            res.path_length <= len_inc;
            state           <= S_RES;
          end else if (beyond) begin
            // walk ran off the bottom of the table
            res.status      <= (opcode == ibst_pkg::OP_INSERT) ? ibst_pkg::ST_BEYOND
                                                               : ibst_pkg::ST_NOT_FOUND;
            res.slot_index  <= '0;
            res.path_length <= len_inc;
            state           <= S_RES;
          end else begin
            idx <= child[ibst_pkg::IDX_W-1:0];
            len <= len_inc;
          end
        end
        S_RES: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // read and write never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem.we && mem.re))
    else $error("RAM read and write in the same cycle");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= ibst_pkg::CNT_W'(ibst_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // storing a valid entry bumps the count
  a_count_tracks_insert: assert property (@(posedge clk) disable iff (rst)
    (mem.we && mem.wdata.valid) |=> (count == $past(count) + 1'b1))
    else $error("entry count missed an insert");

  // a found result always compared at least one node
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ibst_pkg::ST_FOUND) |-> (res.path_length != '0))
    else $error("found result with zero path length");

endmodule

// ===== rtl/implicit_array_bst_engine_core.sv =====
// ----------------------------------------------------------------------------
// implicit_array_bst_engine_core
// Binary search tree held in an implicit array: insert and search of keys.
// ----------------------------------------------------------------------------
// After reset the block clears all TABLE_DEPTH (1024) slots of the entry
// RAM and holds req_ready low until that is done. Each item then passes
// through an accept state, one walk step per tree slot visited (one read of
// the entry RAM per level, the compare on the returned data picks the next
// slot), and a result state that hands the result to the output register;
// an insert into a full table goes straight from accept to result. Items are
// handled one at a time; a result waiting in the output register does not
// stop the next item from being accepted and walked.
module implicit_array_bst_engine_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ibst_pkg::in_item_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output ibst_pkg::out_item_t  rsp
);

  ibst_pkg::mem_req_t              mem;
  ibst_pkg::entry_t                rd_entry;
  logic [ibst_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                            res_valid;
  logic                            res_ready;
  ibst_pkg::out_item_t             res;

  // walker
  ibst_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .mem       (mem),
    .rdata     (rd_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // entry RAM: valid bit and key per slot
  ibst_ram #(
    .WIDTH (ibst_pkg::ENTRY_W),
    .DEPTH (ibst_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = ibst_pkg::entry_t'(ram_rdata);

  // output register
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (res_ready) begin
        rsp_valid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule
